// File: rtl/rgb_3x3_convolution_defines.svh
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_defines.svh
// Assertion macros used by the convolution top level.
// ----------------------------------------------------------------------------
`ifndef RGB_3X3_CONVOLUTION_DEFINES_SVH
`define RGB_3X3_CONVOLUTION_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RCONV_ASSERT_IMP(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define RCONV_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

// File: rtl/rconv_pkg.sv
// ----------------------------------------------------------------------------
// rconv_pkg
// Shared types and constants of the RGB 3x3 convolution block.
// ----------------------------------------------------------------------------
package rconv_pkg;

    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int TAP_W          = 5;
    localparam int TAPS_W         = 45;
    localparam int SUM_W          = 17;   // |sum| <= 9*255*16
    localparam int MAG_W          = 16;

    localparam logic [2:0] REG_WIDTH   = 3'd0;
    localparam logic [2:0] REG_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_TAPS    = 3'd2;
    localparam logic [2:0] REG_DIVISOR = 3'd3;
    localparam logic [2:0] REG_BIAS    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIVIDE,
        ST_SAT,
        ST_OUT
    } back_state_t;

    function automatic logic signed [SUM_W-1:0] finish_add(
        input logic signed [SUM_W-1:0] q,
        input logic [7:0] b
    );
        finish_add = q + $signed({{(SUM_W-8){1'b0}}, b});
    endfunction

    function automatic logic [7:0] saturate(input logic signed [SUM_W-1:0] v);
        logic [7:0] r;
        if (v < 0) begin
            r = 8'd0;
        end else if (v > 255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        saturate = r;
    endfunction

endpackage

// File: rtl/rconv_front.sv
// ----------------------------------------------------------------------------
// rconv_front
// Accepts items, writes pixels into the frame store, queues compute requests.
// ----------------------------------------------------------------------------
module rconv_front
    import rconv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int YW = $clog2(MAX_HEIGHT)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        mode,
    input  logic [6:0]  pos_x,
    input  logic [6:0]  pos_y,
    input  logic [23:0] pixel,
    input  logic [XW:0] width_lim,
    input  logic [YW:0] height_lim,
    input  logic        rd_busy,
    output logic        wr_en,
    output logic [XW+YW-1:0] wr_addr,
    output logic [23:0] wr_data,
    output logic        q_valid,
    input  logic        q_ready,
    output logic [6:0]  q_x,
    output logic [6:0]  q_y
);
    // Two-entry request queue.
    logic [6:0] qx_reg [2];
    logic [6:0] qy_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       push, pop, in_frame, in_store;

    // Hold a pixel write until no earlier request is left to read the store.
    assign s_ready  = mode ? (cnt_reg != 2'd2) : ((cnt_reg == 2'd0) && !rd_busy);
    assign in_store = ({25'd0, pos_x} < MAX_WIDTH) && ({25'd0, pos_y} < MAX_HEIGHT);
    assign in_frame = ({25'd0, pos_x} < 32'(width_lim)) &&
                      ({25'd0, pos_y} < 32'(height_lim));

    assign push    = s_valid && s_ready && mode && in_frame;
    assign pop     = q_valid && q_ready;
    assign wr_en   = s_valid && s_ready && !mode && in_store;
    assign wr_addr = {YW'(pos_y), XW'(pos_x)};
    assign wr_data = pixel;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_x     = qx_reg[rp_reg];
    assign q_y     = qy_reg[rp_reg];

    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (pop) begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            qx_reg[wp_reg] <= pos_x;
            qy_reg[wp_reg] <= pos_y;
        end
    end
endmodule

// File: rtl/rconv_back.sv
// ----------------------------------------------------------------------------
// rconv_back
// Reads nine neighbours, accumulates per channel, divides serially, saturates.
// ----------------------------------------------------------------------------
module rconv_back
    import rconv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int XW = $clog2(MAX_WIDTH),
    parameter int YW = $clog2(MAX_HEIGHT)
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  logic [6:0]  q_x,
    input  logic [6:0]  q_y,
    input  logic [XW:0] width_lim,
    input  logic [YW:0] height_lim,
    input  logic [TAPS_W-1:0] taps,
    input  logic [7:0]  div,
    input  logic [7:0]  bias,
    input  logic        wr_en,
    input  logic [XW+YW-1:0] wr_addr,
    input  logic [23:0] wr_data,
    output logic        rd_busy,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_pixel
);
    logic [23:0] store [2**(XW+YW)];
    logic [23:0] rd_reg;

    back_state_t state_reg, state_next;
    logic [XW-1:0] x_reg, nx;
    logic [YW-1:0] y_reg, ny;
    logic [3:0]  k_reg;       // read index 0..9
    logic        rv_reg;      // read data valid
    logic [3:0]  kd_reg;      // tap index of read data
    logic signed [SUM_W-1:0] acc_reg [3];
    logic [1:0]  ch_reg;
    logic [4:0]  bit_reg;
    logic [MAG_W-1:0] quo_reg;
    logic [8:0]  rem_reg;
    logic [7:0]  res_reg [3];
    logic [23:0] out_reg;
    logic        out_v_reg;
    logic [1:0]  di, dj;
    logic [XW:0] xs;
    logic [YW:0] ys;
    logic [7:0]  dv;
    logic signed [TAP_W-1:0] tap;
    logic [MAG_W-1:0] mag;
    logic        neg;
    logic [8:0]  trial;
    logic signed [SUM_W-1:0] qs;

    assign dv = (div == 8'd0) ? 8'd1 : div;
    assign di = (k_reg < 4'd3) ? 2'd0 : (k_reg < 4'd6) ? 2'd1 : 2'd2;
    assign dj = 2'(k_reg - 4'(di) * 4'd3);

    always_comb begin
        xs = {1'b0, x_reg} + {{(XW-1){1'b0}}, di};
        if (xs == '0) begin
            nx = XW'(width_lim - 1'b1);
        end else if (xs - 1'b1 >= width_lim) begin
            nx = XW'(xs - 1'b1 - width_lim);
        end else begin
            nx = XW'(xs - 1'b1);
        end
        ys = {1'b0, y_reg} + {{(YW-1){1'b0}}, dj};
        if (ys == '0) begin
            ny = YW'(height_lim - 1'b1);
        end else if (ys - 1'b1 >= height_lim) begin
            ny = YW'(ys - 1'b1 - height_lim);
        end else begin
            ny = YW'(ys - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store[wr_addr] <= wr_data;
        end
        rd_reg <= store[{ny, nx}];
    end

    assign tap = $signed(taps[TAP_W*kd_reg +: TAP_W]);
    assign neg = acc_reg[ch_reg] < 0;
    assign mag = neg ? MAG_W'(-acc_reg[ch_reg]) : MAG_W'(acc_reg[ch_reg]);
    assign trial = {rem_reg[7:0], mag[bit_reg[3:0]]};
    assign qs = neg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (q_valid) begin state_next = ST_READ; end
            ST_READ:   if (k_reg == 4'd9 && !rv_reg) begin state_next = ST_DIVIDE; end
            ST_DIVIDE: if (bit_reg == 5'd0) begin state_next = ST_SAT; end
            ST_SAT:    state_next = (ch_reg == 2'd2) ? ST_OUT : ST_DIVIDE;
            ST_OUT:    if (!out_v_reg || m_ready) begin state_next = ST_IDLE; end
            default:   state_next = ST_IDLE;
        endcase
    end

    assign q_ready = (state_reg == ST_IDLE);
    assign rd_busy = (state_reg == ST_READ);
    assign m_valid = out_v_reg;
    assign m_pixel = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            out_v_reg <= 1'b0;
            rv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= (state_reg == ST_READ) && (k_reg != 4'd9);
            if (state_reg == ST_OUT && (!out_v_reg || m_ready)) begin
                out_v_reg <= 1'b1;
            end else if (m_ready) begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        kd_reg <= k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                x_reg  <= XW'(q_x);
                y_reg  <= YW'(q_y);
                k_reg  <= 4'd0;
                ch_reg <= 2'd0;
                bit_reg <= 5'(MAG_W - 1);
                rem_reg <= 9'd0;
                quo_reg <= '0;
                for (int c = 0; c < 3; c++) begin
                    acc_reg[c] <= '0;
                end
            end
            ST_READ: begin
                if (k_reg != 4'd9) begin
                    k_reg <= k_reg + 4'd1;
                end
                if (rv_reg) begin
                    for (int c = 0; c < 3; c++) begin
                        acc_reg[c] <= acc_reg[c] +
                            SUM_W'($signed({1'b0, rd_reg[8*c +: 8]})) * SUM_W'(tap);
                    end
                end
            end
            ST_DIVIDE: begin
                // restoring division, one quotient bit per cycle
                if (trial >= {1'b0, dv}) begin
                    rem_reg <= trial - {1'b0, dv};
                    quo_reg[bit_reg[3:0]] <= 1'b1;
                end else begin
                    rem_reg <= trial;
                end
                bit_reg <= bit_reg - 5'd1;
            end
            ST_SAT: begin
                res_reg[ch_reg] <= saturate(finish_add(qs, bias));
                ch_reg  <= ch_reg + 2'd1;
                bit_reg <= 5'(MAG_W - 1);
                rem_reg <= 9'd0;
                quo_reg <= '0;
            end
            ST_OUT: begin
                if (!out_v_reg || m_ready) begin
                    out_reg <= {res_reg[2], res_reg[1], res_reg[0]};
                end
            end
            default: begin
            end
        endcase
    end
endmodule

// File: rtl/rgb_3x3_convolution.sv
// ----------------------------------------------------------------------------
// rgb_3x3_convolution
// 3x3 RGB convolution over a stored frame, with a write/compute stream port.
// ----------------------------------------------------------------------------
// A compute item, once the back end is free, takes the request from the queue,
// streams the nine neighbours through the single frame-store read port, then
// per channel runs a restoring divider over the 16-bit magnitude and one
// saturation step, and finally loads the output register, where a stalled
// result waits until it is taken. A write item stores one pixel, but waits
// while a compute request is queued or its neighbours are being read, so a
// write never overtakes an earlier request.
// A two-entry request queue lets new requests enter meanwhile.
// The frame store has no reset; only written pixels may be filtered.
`include "rgb_3x3_convolution_defines.svh"
module rgb_3x3_convolution
    import rconv_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,    // mode
    input  logic [39:0] s_tdata,    // pos_x, pos_y, in_red, in_green, in_blue, pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // out_red, out_green, out_blue
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [44:0] cfg_wdata
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);

    logic [7:0] width_reg, height_reg, div_reg, bias_reg;
    logic [TAPS_W-1:0] taps_reg;
    logic [XW:0] width_lim;
    logic [YW:0] height_lim;
    logic q_valid, q_ready, wr_en, rd_busy;
    logic [6:0] q_x, q_y;
    logic [XW+YW-1:0] wr_addr;
    logic [23:0] wr_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 8'd128;
            height_reg <= 8'd128;
            taps_reg   <= '0;
            div_reg    <= 8'd1;
            bias_reg   <= 8'd0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_WIDTH:   width_reg  <= cfg_wdata[7:0];
                REG_HEIGHT:  height_reg <= cfg_wdata[7:0];
                REG_TAPS:    taps_reg   <= cfg_wdata;
                REG_DIVISOR: div_reg    <= cfg_wdata[7:0];
                REG_BIAS:    bias_reg   <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (width_reg == 8'd0) begin
            width_lim = (XW+1)'(1);
        end else if ({24'd0, width_reg} > MAX_WIDTH) begin
            width_lim = (XW+1)'(MAX_WIDTH);
        end else begin
            width_lim = (XW+1)'(width_reg);
        end
        if (height_reg == 8'd0) begin
            height_lim = (YW+1)'(1);
        end else if ({24'd0, height_reg} > MAX_HEIGHT) begin
            height_lim = (YW+1)'(MAX_HEIGHT);
        end else begin
            height_lim = (YW+1)'(height_reg);
        end
    end

    rconv_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .aclk, .aresetn,
        .s_valid(s_tvalid), .s_ready(s_tready), .mode(s_tuser),
        .pos_x(s_tdata[6:0]), .pos_y(s_tdata[13:7]), .pixel(s_tdata[37:14]),
        .width_lim, .height_lim, .rd_busy, .wr_en, .wr_addr, .wr_data,
        .q_valid, .q_ready, .q_x, .q_y
    );

    rconv_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_x, .q_y,
        .width_lim, .height_lim, .taps(taps_reg), .div(div_reg), .bias(bias_reg),
        .wr_en, .wr_addr, .wr_data, .rd_busy,
        .m_valid(m_tvalid), .m_ready(m_tready), .m_pixel(m_tdata)
    );

    `RCONV_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `RCONV_ASSERT_IMP(a_wr_only_write, aclk, aresetn, wr_en, s_tvalid && s_tready && !s_tuser)
    `RCONV_ASSERT_IMP(a_queue_full, aclk, aresetn, !s_tready && s_tuser, q_valid)
endmodule

// File: sim/rgb_3x3_convolution_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_3x3_convolution_tb
// Self-checking bench for the 3x3 RGB convolution block.
// ----------------------------------------------------------------------------
// Each phase programs the registers while the block is idle, fills the frame
// in use with known pixels and then sends directed items or random writes
// and filter requests. A scoreboard keeps its own copy of the frame and the
// registers, predicts every filtered pixel and checks the results in order.
// ----------------------------------------------------------------------------
module rgb_3x3_convolution_tb;
    import rconv_pkg::*;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_FILTER = 1'b1;
    localparam int   STORE_W     = 128;
    localparam int   STORE_H     = 128;
    localparam int   DRAIN_WAIT  = 100;
    localparam int   LONG_HOLD   = 400;
    localparam int   CYCLE_LIMIT = 2000000;

    class pixel_scoreboard;
        bit [23:0] frame [0:STORE_W*STORE_H-1];
        bit [23:0] expected_pixels [$];
        bit [7:0]  width_reg, height_reg, divisor_reg, bias_reg;
        bit [44:0] taps_reg;
        int        errors, writes, filters, results;

        function new();
            width_reg   = 8'd128;
            height_reg  = 8'd128;
            taps_reg    = '0;
            divisor_reg = 8'd1;
            bias_reg    = 8'd0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [44:0] value);
            case (idx)
                REG_WIDTH:   width_reg   = value[7:0];
                REG_HEIGHT:  height_reg  = value[7:0];
                REG_TAPS:    taps_reg    = value;
                REG_DIVISOR: divisor_reg = value[7:0];
                REG_BIAS:    bias_reg    = value[7:0];
                default: ;
            endcase
        endfunction

        function int dim(bit [7:0] v, int limit);
            if (v == 0) return 1;
            if (v > limit) return limit;
            return v;
        endfunction

        function int eff_width();
            return dim(width_reg, STORE_W);
        endfunction

        function int eff_height();
            return dim(height_reg, STORE_H);
        endfunction

        // neighbour at pos+delta-1, wrapped once into the frame
        function int wrap(int pos, int delta, int lim);
            int c;
            c = pos + delta;
            if (c == 0) return lim - 1;
            c = c - 1;
            if (c >= lim) c = c - lim;
            return c;
        endfunction

        function bit [23:0] filter_pixel(int px, int py);
            int w, h, dv, nx, ny, q;
            int sums [3];
            logic signed [4:0] tap;
            bit [23:0] pix, res;
            w  = eff_width();
            h  = eff_height();
            dv = (divisor_reg == 0) ? 1 : int'(divisor_reg);
            sums = '{0, 0, 0};
            for (int i = 0; i < 3; i++) begin
                nx = wrap(px, i, w);
                for (int j = 0; j < 3; j++) begin
                    ny  = wrap(py, j, h);
                    pix = frame[ny*STORE_W + nx];
                    tap = taps_reg[5*(i*3+j) +: 5];
                    for (int c = 0; c < 3; c++)
                        sums[c] += int'(pix[8*c +: 8]) * int'(tap);
                end
            end
            for (int c = 0; c < 3; c++) begin
                q = sums[c] / dv + int'(bias_reg);   // SV division truncates toward zero
                res[8*c +: 8] = (q < 0) ? 8'd0 : (q > 255) ? 8'd255 : q[7:0];
            end
            return res;
        endfunction

        function void note_input(logic mode, logic [39:0] data);
            int px, py;
            px = int'(data[6:0]);
            py = int'(data[13:7]);
            if (mode == MODE_WRITE) begin
                writes++;
                frame[py*STORE_W + px] = data[37:14];
            end else begin
                filters++;
                if (px < eff_width() && py < eff_height())
                    expected_pixels.push_back(filter_pixel(px, py));
            end
        endfunction

        function void report(string what, int got, int want);
            errors++;
            $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        endfunction

        function void check_result(logic [23:0] data);
            bit [23:0] want;
            results++;
            if (expected_pixels.size() == 0) begin
                report("unexpected result, red", data[7:0], -1);
                return;
            end
            want = expected_pixels.pop_front();
            if (data[7:0]   !== want[7:0])   report("red",   data[7:0],   want[7:0]);
            if (data[15:8]  !== want[15:8])  report("green", data[15:8],  want[15:8]);
            if (data[23:16] !== want[23:16]) report("blue",  data[23:16], want[23:16]);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic        s_tuser   = 1'b0;
    logic [39:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = '0;
    logic [44:0] cfg_wdata = '0;

    pixel_scoreboard sb = new();
    bit steady = 1'b0;   // no idling on either side while set
    int cycles = 0;

    rgb_3x3_convolution i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    // Result side: random ready gaps, one long hold-off to back up the block.
    initial begin : result_side
        int gap, seen;
        seen = 0;
        @(posedge aresetn);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 3);
            if (seen == 60) gap = LONG_HOLD;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
            seen++;
        end
    end

    function automatic logic [39:0] pack_item(int x, int y, bit [23:0] rgb);
        return {2'b00, rgb, y[6:0], x[6:0]};
    endfunction

    // Leaves tvalid high after the transfer; stop_sending drops it, as does the next call when it waits a gap.
    task automatic send_item(logic mode, logic [39:0] data);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(mode, data);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [44:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.set_reg(idx, value);
    endtask

    // Program all registers with the block idle, then fill the frame in use.
    task automatic setup_phase(bit [7:0] w, bit [7:0] h, bit [44:0] taps, bit [7:0] dv,
                               bit [7:0] b);
        stop_sending();
        wait_drain();
        repeat (DRAIN_WAIT) @(posedge aclk);
        write_reg(REG_WIDTH, 45'(w));
        write_reg(REG_HEIGHT, 45'(h));
        write_reg(REG_TAPS, taps);
        write_reg(REG_DIVISOR, 45'(dv));
        write_reg(REG_BIAS, 45'(b));
        cfg_we <= 1'b0;
        for (int y = 0; y < sb.eff_height(); y++)
            for (int x = 0; x < sb.eff_width(); x++)
                send_item(MODE_WRITE, pack_item(x, y, 24'($urandom)));
    endtask

    task automatic random_items(int n);
        int r, x, y;
        for (int k = 0; k < n; k++) begin
            if (k == n / 2) begin
                // pause the input until every pending result is out
                stop_sending();
                wait_drain();
            end
            r = $urandom_range(0, 99);
            if (r < 45 && $urandom_range(0, 3) == 0 || r >= 40 && r < 46) begin
                x = $urandom_range(0, STORE_W - 1);
                y = $urandom_range(0, STORE_H - 1);
            end else begin
                x = $urandom_range(0, sb.eff_width() - 1);
                y = $urandom_range(0, sb.eff_height() - 1);
            end
            if (r < 40) send_item(MODE_WRITE, pack_item(x, y, 24'($urandom)));
            else send_item(MODE_FILTER, pack_item(x, y, 24'($urandom)));
        end
    endtask

    initial begin : stimulus
        bit [44:0] taps;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: strongest positive taps, zero divisor, corners and outside the frame.
        setup_phase(8'd4, 8'd4, {9{5'b01111}}, 8'd0, 8'd0);
        send_item(MODE_WRITE, pack_item(0, 0, 24'hFFFFFF));
        send_item(MODE_WRITE, pack_item(3, 3, 24'h000000));
        send_item(MODE_WRITE, pack_item(127, 127, 24'hFFFFFF));
        send_item(MODE_FILTER, pack_item(0, 0, 24'hFFFFFF));
        send_item(MODE_FILTER, pack_item(3, 3, 24'h0));
        send_item(MODE_FILTER, pack_item(3, 0, 24'h0));
        send_item(MODE_FILTER, pack_item(4, 0, 24'h0));
        send_item(MODE_FILTER, pack_item(0, 127, 24'h0));
        send_item(MODE_FILTER, pack_item(127, 127, 24'h0));

        // Widest row (register above the maximum), most negative taps, largest divisor.
        setup_phase(8'd255, 8'd1, {9{5'b10000}}, 8'd255, 8'd255);
        random_items(100);
        // Zero width reads as one column, tallest frame.
        setup_phase(8'd0, 8'd128, {9{5'b11111}}, 8'd3, 8'd128);
        random_items(100);

        for (int p = 0; p < 7; p++) begin
            steady = (p % 3 == 2);
            taps   = 45'({$urandom, $urandom});
            setup_phase(8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)), taps,
                        ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom_range(1, 40)),
                        8'($urandom_range(0, 255)));
            random_items(120);
        end
        steady = 1'b0;
        stop_sending();
        wait_drain();
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (sb.pending() != 0) sb.report("results missing", 0, sb.pending());
        $display("covered %0d pixel writes and %0d filter requests, %0d results checked",
                 sb.writes, sb.filters, sb.results);
        $display("frames from 1 column to 128, wrapped edges, saturation and idle gaps");
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
